/* rtl/swsc_pkg.sv */
package swsc_pkg;

    localparam int FLOW_COUNT_DEF = 128;
    localparam int SEQ_WIDTH_DEF  = 16;

    localparam int FLOW_ID_W = 7;
    localparam int FIELD_W   = 16;
    localparam int FLOWS_W   = 8;

    localparam logic [15:0] TOTAL_PACKETS_RST  = 16'd100;
    localparam logic [7:0]  ACTIVE_FLOWS_RST   = 8'd1;
    localparam logic [15:0] INITIAL_WINDOW_RST = 16'd64;

    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_TOTAL_PACKETS  = 2'd0,
        REG_ACTIVE_FLOWS   = 2'd1,
        REG_INITIAL_WINDOW = 2'd2,
        REG_NONE           = 2'd3
    } t_reg_idx;

    typedef enum logic {
        MODE_SEND = 1'b0,
        MODE_ACK  = 1'b1
    } t_mode;

    typedef struct packed {
        logic [FIELD_W-1:0] total_packets;
        logic [FLOWS_W-1:0] active_flows;
        logic [FIELD_W-1:0] initial_window;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } t_state;

endpackage

/* rtl/swsc_ram.sv */
module swsc_ram
    import swsc_pkg::*;
#(
    parameter int DEPTH = FLOW_COUNT_DEF,
    parameter int AW    = 7,
    parameter int WIDTH = 81
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/swsc_cfg.sv */
module swsc_cfg
    import swsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // The word address maps straight onto the register index; index three is unused.
    assign w_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_packets  <= TOTAL_PACKETS_RST;
            r_cfg.active_flows   <= ACTIVE_FLOWS_RST;
            r_cfg.initial_window <= INITIAL_WINDOW_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TOTAL_PACKETS:  r_cfg.total_packets  <= pwdata[FIELD_W-1:0];
                REG_ACTIVE_FLOWS:   r_cfg.active_flows   <= pwdata[FLOWS_W-1:0];
                REG_INITIAL_WINDOW: r_cfg.initial_window <= pwdata[FIELD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TOTAL_PACKETS:  prdata = {16'd0, r_cfg.total_packets};
            REG_ACTIVE_FLOWS:   prdata = {24'd0, r_cfg.active_flows};
            REG_INITIAL_WINDOW: prdata = {16'd0, r_cfg.initial_window};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/swsc_core.sv */
module swsc_core
    import swsc_pkg::*;
#(
    parameter int FLOW_COUNT = FLOW_COUNT_DEF,
    parameter int SEQ_WIDTH  = SEQ_WIDTH_DEF,
    parameter int AW         = 7,
    parameter int EW         = 81
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [FLOW_ID_W-1:0] i_flow_id,
    input  logic [FIELD_W-1:0]   i_ack_number,
    input  logic [FIELD_W-1:0]   i_peer_window,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FIELD_W-1:0]   o_first_seq,
    output logic [FIELD_W-1:0]   o_grant_count,
    output logic [FIELD_W-1:0]   o_usable_window,
    output logic                 o_flow_done,
    output logic                 o_bad_flow,
    output logic                 o_mem_we,
    output logic [AW-1:0]        o_mem_waddr,
    output logic [EW-1:0]        o_mem_wdata,
    output logic                 o_mem_re,
    output logic [AW-1:0]        o_mem_raddr,
    input  logic [EW-1:0]        i_mem_rdata
);

    localparam int CW = (SEQ_WIDTH > FIELD_W) ? SEQ_WIDTH : FIELD_W;

    function automatic logic [FIELD_W-1:0] win_left(input logic [FIELD_W-1:0]   w,
                                                    input logic [SEQ_WIDTH-1:0] fl);
        logic [CW-1:0] we;
        logic [CW-1:0] fe;
        logic [CW-1:0] d;
        begin
            we = CW'(w);
            fe = CW'(fl);
            d  = we - fe;
            win_left = (we > fe) ? d[FIELD_W-1:0] : '0;
        end
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;

    // Item context captured at acceptance.
    logic                 r_mode;
    logic                 r_bad;
    logic [SEQ_WIDTH-1:0] r_ackm;
    logic [FIELD_W-1:0]   r_peer;
    logic [AW-1:0]        r_addr;

    // Working copy of the flow entry.
    logic [SEQ_WIDTH-1:0] r_next;
    logic [SEQ_WIDTH-1:0] r_acked;
    logic [FIELD_W-1:0]   r_written;
    logic [FIELD_W-1:0]   r_adv;
    logic                 r_seen;
    logic [FIELD_W-1:0]   r_eff;
    logic [FIELD_W-1:0]   r_w;
    logic [SEQ_WIDTH-1:0] r_fl;
    logic [FIELD_W-1:0]   r_avail;
    logic [FIELD_W-1:0]   r_remain;
    logic                 r_newer;
    logic [FIELD_W-1:0]   r_grant;
    logic [FIELD_W-1:0]   r_first;

    logic [FIELD_W-1:0] r_o_first;
    logic [FIELD_W-1:0] r_o_grant;
    logic [FIELD_W-1:0] r_o_usable;
    logic               r_o_done;
    logic               r_o_bad;

    logic                     w_accept;
    logic                     w_bad_in;
    logic [AW+FLOW_ID_W-1:0]  w_fid_ext;
    logic                     w_advance;

    logic [SEQ_WIDTH-1:0] m_next;
    logic [SEQ_WIDTH-1:0] m_acked;
    logic [FIELD_W-1:0]   m_written;
    logic [FIELD_W-1:0]   m_adv;
    logic                 m_seen;
    logic [FIELD_W-1:0]   m_eff;

    logic                 rd_newer;
    logic [SEQ_WIDTH-1:0] rd_acked;
    logic [SEQ_WIDTH-1:0] rd_fl;
    logic [FIELD_W-1:0]   rd_w;
    logic [FIELD_W-1:0]   rd_remain;

    logic [FIELD_W-1:0]   c_grant;

    logic [FIELD_W-1:0]   wr_left;
    logic [FIELD_W-1:0]   wr_eff;
    logic                 wr_done;

    assign w_accept  = i_valid && o_ready;
    assign w_fid_ext = {{AW{1'b0}}, i_flow_id};
    assign w_bad_in  = ({1'b0, i_flow_id} >= i_cfg.active_flows) ||
                       (int'(i_flow_id) >= FLOW_COUNT);

    // The result register frees up when it is empty or being taken.
    assign w_advance = (r_state == ST_WRITE) && (!r_out_valid || i_ready);

    assign {m_next, m_acked, m_written, m_adv, m_seen, m_eff} = i_mem_rdata;

    always_comb begin
        rd_newer  = r_ackm > m_acked;
        rd_acked  = (r_mode == MODE_ACK && rd_newer) ? r_ackm : m_acked;
        rd_fl     = m_next - rd_acked - SEQ_WIDTH'(1);
        if (r_mode == MODE_ACK) begin
            rd_w = r_peer;
        end else begin
            rd_w = m_seen ? m_adv : i_cfg.initial_window;
        end
        rd_remain = (m_written < i_cfg.total_packets) ?
                    (i_cfg.total_packets - m_written) : '0;
    end

    assign c_grant = (r_mode == MODE_ACK) ? '0 :
                     ((r_avail < r_remain) ? r_avail : r_remain);

    always_comb begin
        wr_left = win_left(r_w, r_fl);
        wr_eff  = (r_mode == MODE_ACK && r_newer) ? wr_left : r_eff;
        wr_done = (r_written >= i_cfg.total_packets) && (r_fl == '0);
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(FLOW_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_CALC;
            ST_CALC:  n_state = ST_WRITE;
            ST_WRITE: begin
                if (w_advance) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_bad  <= w_bad_in;
            r_ackm <= SEQ_WIDTH'(i_ack_number);
            r_peer <= i_peer_window;
            r_addr <= w_fid_ext[AW-1:0];
        end
        if (r_state == ST_READ) begin
            r_next    <= m_next;
            r_acked   <= rd_acked;
            r_written <= m_written;
            r_adv     <= (r_mode == MODE_ACK) ? r_peer : m_adv;
            r_seen    <= (r_mode == MODE_ACK) || m_seen;
            r_eff     <= m_eff;
            r_w       <= rd_w;
            r_fl      <= rd_fl;
            r_avail   <= win_left(rd_w, rd_fl);
            r_remain  <= rd_remain;
            r_newer   <= rd_newer;
        end
        if (r_state == ST_CALC) begin
            r_first   <= FIELD_W'(r_next);
            r_grant   <= c_grant;
            r_next    <= r_next + SEQ_WIDTH'(c_grant);
            r_fl      <= r_fl + SEQ_WIDTH'(c_grant);
            r_written <= r_written + c_grant;
        end
        if (w_advance) begin
            r_o_bad <= r_bad;
            if (r_bad) begin
                r_o_first  <= '0;
                r_o_grant  <= '0;
                r_o_usable <= '0;
                r_o_done   <= 1'b0;
            end else begin
                r_o_first  <= (r_mode == MODE_ACK) ? '0 : r_first;
                r_o_grant  <= r_grant;
                r_o_usable <= (r_mode == MODE_ACK) ? wr_eff : wr_left;
                r_o_done   <= wr_done;
            end
        end
    end

    // Memory port control: the clearing pass owns the write port after reset.
    always_comb begin
        o_mem_re    = w_accept;
        o_mem_raddr = w_fid_ext[AW-1:0];
        if (r_state == ST_CLEAR) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_clr_addr;
            o_mem_wdata = {SEQ_WIDTH'(1), {SEQ_WIDTH{1'b0}}, {FIELD_W{1'b0}},
                           {FIELD_W{1'b0}}, 1'b0, {FIELD_W{1'b0}}};
        end else begin
            o_mem_we    = w_advance && !r_bad;
            o_mem_waddr = r_addr;
            o_mem_wdata = {r_next, r_acked, r_written, r_adv, r_seen, wr_eff};
        end
    end

    assign o_valid         = r_out_valid;
    assign o_first_seq     = r_o_first;
    assign o_grant_count   = r_o_grant;
    assign o_usable_window = r_o_usable;
    assign o_flow_done     = r_o_done;
    assign o_bad_flow      = r_o_bad;

endmodule

/* rtl/sliding_window_sender_credit.sv */
// Sender credit table for sliding-window flow control. Per-flow state (next
// sequence, last cumulative ack, packets written, advertised window, effective
// window) lives in one single-port-read, single-port-write RAM. A send item
// grants min(window minus packets in flight, packets left to write); an ack
// item stores the peer window and, on a newer ack, moves the ack position and
// refreshes the effective window. Each item passes four steps (accept, RAM
// read, grant calculation, write-back) of the flow entry's read-modify-write;
// write-back waits while the output holds an untaken result. The next item
// is accepted once the previous one is written back, even while its result
// waits on the output. After reset the block clears all FLOW_COUNT RAM entries
// and accepts no item until done; configuration writes are taken at any time.
module sliding_window_sender_credit
    import swsc_pkg::*;
#(
    parameter int FLOW_COUNT = FLOW_COUNT_DEF,
    parameter int SEQ_WIDTH  = SEQ_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [FLOW_ID_W-1:0]  i_flow_id,
    input  logic [FIELD_W-1:0]    i_ack_number,
    input  logic [FIELD_W-1:0]    i_peer_window,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FIELD_W-1:0]    o_first_seq,
    output logic [FIELD_W-1:0]    o_grant_count,
    output logic [FIELD_W-1:0]    o_usable_window,
    output logic                  o_flow_done,
    output logic                  o_bad_flow
);

    localparam int AW = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
    localparam int EW = 2 * SEQ_WIDTH + 3 * FIELD_W + 1;

    t_cfg          w_cfg;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [EW-1:0] w_rdata;

    swsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    swsc_ram #(
        .DEPTH (FLOW_COUNT),
        .AW    (AW),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    swsc_core #(
        .FLOW_COUNT (FLOW_COUNT),
        .SEQ_WIDTH  (SEQ_WIDTH),
        .AW         (AW),
        .EW         (EW)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_flow_id       (i_flow_id),
        .i_ack_number    (i_ack_number),
        .i_peer_window   (i_peer_window),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_first_seq     (o_first_seq),
        .o_grant_count   (o_grant_count),
        .o_usable_window (o_usable_window),
        .o_flow_done     (o_flow_done),
        .o_bad_flow      (o_bad_flow),
        .o_mem_we        (w_we),
        .o_mem_waddr     (w_waddr),
        .o_mem_wdata     (w_wdata),
        .o_mem_re        (w_re),
        .o_mem_raddr     (w_raddr),
        .i_mem_rdata     (w_rdata)
    );

endmodule
